### hw/rtl/ifla_pkg.sv
package ifla_pkg;

    localparam int RECORD_COUNT = 256;
    localparam int LINK_W       = $clog2(RECORD_COUNT);

    localparam int OPC_W = 3;
    localparam int IDX_W = 8;
    localparam int GOT_W = 8;
    localparam int ERR_W = 2;

    typedef logic [LINK_W-1:0] t_link;

    typedef enum logic [OPC_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_START  = 3'd1,
        OP_TAKE   = 3'd2,
        OP_APPEND = 3'd3,
        OP_GIVE   = 3'd4
    } t_opcode;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_INDEX = 2'd2
    } t_err;

    // one write port and one read port of a link memory
    typedef struct packed {
        logic  we;
        t_link waddr;
        t_link wdata;
        t_link raddr;
    } t_mem_req;

    typedef struct packed {
        logic             valid;
        logic [GOT_W-1:0] got;
        t_err             err;
    } t_result;

endpackage

### hw/rtl/ifla_if.sv
interface ifla_req_if;
    logic                        valid;
    logic                        ready;
    logic [ifla_pkg::OPC_W-1:0]  opcode;
    logic [ifla_pkg::IDX_W-1:0]  record_index;

    modport source (output valid, output opcode, output record_index, input ready);
    modport sink   (input valid, input opcode, input record_index, output ready);
endinterface

interface ifla_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ifla_pkg::GOT_W-1:0]  got_index;
    logic [ifla_pkg::ERR_W-1:0]  error_code;

    modport source (output valid, output got_index, output error_code, input ready);
    modport sink   (input valid, input got_index, input error_code, output ready);
endinterface

### hw/rtl/ifla_ram.sv
module ifla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read of the entry being written returns the old data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/ifla_ctrl.sv
module ifla_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ifla_req_if.sink           i_req,
    input  logic               i_slot_free,
    output ifla_pkg::t_result  o_result,
    output ifla_pkg::t_mem_req o_nxt,
    output ifla_pkg::t_mem_req o_prv,
    input  ifla_pkg::t_link    i_nxt_rd,
    input  ifla_pkg::t_link    i_prv_rd
);
    import ifla_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_INIT = 11'b000_0000_0010,
        S_CLR  = 11'b000_0000_0100,
        S_POP1 = 11'b000_0000_1000,
        S_POP2 = 11'b000_0001_0000,
        S_APP1 = 11'b000_0010_0000,
        S_APP2 = 11'b000_0100_0000,
        S_GB1  = 11'b000_1000_0000,
        S_GB2  = 11'b001_0000_0000,
        S_GB3  = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    t_state  r_state, n_state;
    t_link   r_cnt, n_cnt;
    t_link   r_head, n_head;
    t_link   r_tail, n_tail;
    t_opcode r_op, n_op;
    t_link   r_idx, n_idx;
    t_link   r_w, n_w;
    t_link   r_h, n_h;
    t_result r_pend, n_pend;

    logic    accept;
    logic    idx_ok;
    logic    done;
    logic    cnt_last;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign idx_ok      = (i_req.record_index != '0)
                      && (int'(i_req.record_index) < RECORD_COUNT);
    assign cnt_last    = (r_cnt == t_link'(RECORD_COUNT - 1));

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_head   = r_head;
        n_tail   = r_tail;
        n_op     = r_op;
        n_idx    = r_idx;
        n_w      = r_w;
        n_h      = r_h;
        n_pend   = r_pend;
        done     = 1'b0;
        o_result = '{valid: 1'b0, got: '0, err: ERR_OK};
        o_nxt    = '{we: 1'b0, waddr: '0, wdata: '0, raddr: '0};
        o_prv    = '{we: 1'b0, waddr: '0, wdata: '0, raddr: '0};

        unique case (r_state)
            S_INIT, S_CLR: begin
                // rebuild the free ring one entry per cycle
                o_nxt.we    = 1'b1;
                o_nxt.waddr = r_cnt;
                o_nxt.wdata = cnt_last ? '0 : r_cnt + 1'b1;
                o_prv.we    = 1'b1;
                o_prv.waddr = r_cnt;
                o_prv.wdata = (r_cnt == '0) ? t_link'(RECORD_COUNT - 1) : r_cnt - 1'b1;
                n_cnt       = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_cnt = '0;
                    if (r_state == S_CLR) begin
                        n_head = '0;
                        n_tail = '0;
                        done   = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op  = t_opcode'(i_req.opcode);
                    n_idx = t_link'(i_req.record_index);
                    unique case (t_opcode'(i_req.opcode))
                        OP_CLEAR: begin
                            n_state = S_CLR;
                        end
                        OP_START, OP_TAKE: begin
                            o_nxt.raddr = '0;
                            n_state     = S_POP1;
                        end
                        OP_APPEND: begin
                            if (idx_ok) begin
                                n_state = S_APP1;
                            end else begin
                                o_result.err = ERR_INDEX;
                                done         = 1'b1;
                            end
                        end
                        OP_GIVE: begin
                            if (idx_ok) begin
                                o_nxt.raddr = t_link'(i_req.record_index);
                                o_prv.raddr = t_link'(i_req.record_index);
                                n_state     = S_GB1;
                            end else begin
                                o_result.err = ERR_INDEX;
                                done         = 1'b1;
                            end
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_POP1: begin
                if (i_nxt_rd == '0) begin
                    o_result.err = ERR_EMPTY;
                    done         = 1'b1;
                end else begin
                    // fetch the link after the head and detach the head in one go
                    n_w         = i_nxt_rd;
                    o_nxt.raddr = i_nxt_rd;
                    o_nxt.we    = 1'b1;
                    o_nxt.waddr = i_nxt_rd;
                    o_prv.we    = 1'b1;
                    o_prv.waddr = i_nxt_rd;
                    n_state     = S_POP2;
                end
            end
            S_POP2: begin
                o_nxt.we    = 1'b1;
                o_nxt.waddr = '0;
                o_nxt.wdata = i_nxt_rd;
                o_prv.we    = 1'b1;
                o_prv.waddr = i_nxt_rd;
                if (r_op == OP_START) begin
                    n_head = r_w;
                    n_tail = r_w;
                end
                o_result.got = GOT_W'(r_w);
                done         = 1'b1;
            end
            S_APP1: begin
                if (r_tail == '0) begin
                    n_head = r_idx;
                end else begin
                    o_nxt.we    = 1'b1;
                    o_nxt.waddr = r_tail;
                    o_nxt.wdata = r_idx;
                end
                o_prv.we    = 1'b1;
                o_prv.waddr = r_idx;
                o_prv.wdata = r_tail;
                n_state     = S_APP2;
            end
            S_APP2: begin
                o_nxt.we    = 1'b1;
                o_nxt.waddr = r_idx;
                n_tail      = r_idx;
                done        = 1'b1;
            end
            S_GB1: begin
                // unlink: prev in i_prv_rd, next in i_nxt_rd; fetch the free head
                o_nxt.raddr = '0;
                if (i_prv_rd != '0) begin
                    o_nxt.we    = 1'b1;
                    o_nxt.waddr = i_prv_rd;
                    o_nxt.wdata = i_nxt_rd;
                end else if (r_head == r_idx) begin
                    n_head = i_nxt_rd;
                end
                if (i_nxt_rd != '0) begin
                    o_prv.we    = 1'b1;
                    o_prv.waddr = i_nxt_rd;
                    o_prv.wdata = i_prv_rd;
                end else if (r_tail == r_idx) begin
                    n_tail = i_prv_rd;
                end
                n_state = S_GB2;
            end
            S_GB2: begin
                n_h         = i_nxt_rd;
                o_nxt.we    = 1'b1;
                o_nxt.waddr = r_idx;
                o_nxt.wdata = i_nxt_rd;
                o_prv.we    = 1'b1;
                o_prv.waddr = r_idx;
                n_state     = S_GB3;
            end
            S_GB3: begin
                o_nxt.we    = 1'b1;
                o_nxt.waddr = '0;
                o_nxt.wdata = r_idx;
                o_prv.we    = 1'b1;
                o_prv.waddr = r_h;
                o_prv.wdata = r_idx;
                done        = 1'b1;
            end
            S_DONE: begin
                o_result       = r_pend;
                o_result.valid = 1'b1;
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (done) begin
            o_result.valid = 1'b1;
            if (i_slot_free) begin
                n_state = S_IDLE;
            end else begin
                n_pend  = o_result;
                n_state = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_head  <= '0;
            r_tail  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_head  <= n_head;
            r_tail  <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_idx  <= n_idx;
        r_w    <= n_w;
        r_h    <= n_h;
        r_pend <= n_pend;
    end

    a_reset_sweep: assert property (@(posedge i_clk) !i_rst_n |=> r_state == S_INIT)
        else $error("ring rebuild does not start after reset");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !(o_nxt.we || o_prv.we))
        else $error("link memory written outside a request");

    a_init_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INIT |-> !o_result.valid)
        else $error("result offered during the reset rebuild");

    a_pop_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP2 |-> (o_nxt.we && o_nxt.waddr == '0 && o_result.got != '0))
        else $error("pop does not advance the free head");

    a_push_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_GB3 |-> (o_nxt.we && o_nxt.waddr == '0 && o_nxt.wdata != '0))
        else $error("give back does not push a record on the free head");

endmodule

### hw/rtl/indexed_free_list_allocator.sv
// Indexed free-list allocator.
// Requests come in on i_req (opcode, record_index) and each one produces
// exactly one beat on o_rsp (got_index, error_code), in request order.
// The link arrays live in two single-port-write RAMs with a registered
// read; a sequencer reads, modifies and writes them back, one request
// at a time.
// Each request runs through dependent RAM read/write states: take and
// start row pass POP1 and POP2 (only POP1 when the pool is empty), append
// APP1 and APP2, give back GB1, GB2 and GB3; a request rejected for index
// 0 or an unused opcode is answered from idle, and clear rewrites one
// entry of the ring per cycle.
// The response is registered in the output register after the last step.
// After reset the block rebuilds the free ring with i_req.ready low; the
// row is empty.
// A finished response waits in the output register while o_rsp.ready is
// low; the sequencer holds a second finished response internally and
// does not accept new requests until it has been handed over.
module indexed_free_list_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ifla_req_if.sink   i_req,
    ifla_rsp_if.source o_rsp
);
    import ifla_pkg::*;

    t_mem_req nxt_req;
    t_mem_req prv_req;
    t_link    nxt_rd;
    t_link    prv_rd;
    t_result  result;
    logic     slot_free;

    logic             r_out_valid;
    logic [GOT_W-1:0] r_out_got;
    t_err             r_out_err;

    ifla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (RECORD_COUNT)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nxt_req.we),
        .i_waddr (nxt_req.waddr),
        .i_wdata (nxt_req.wdata),
        .i_raddr (nxt_req.raddr),
        .o_rdata (nxt_rd)
    );

    ifla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (RECORD_COUNT)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prv_req.we),
        .i_waddr (prv_req.waddr),
        .i_wdata (prv_req.wdata),
        .i_raddr (prv_req.raddr),
        .o_rdata (prv_rd)
    );

    ifla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_slot_free (slot_free),
        .o_result    (result),
        .o_nxt       (nxt_req),
        .o_prv       (prv_req),
        .i_nxt_rd    (nxt_rd),
        .i_prv_rd    (prv_rd)
    );

    assign slot_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free && result.valid) begin
            r_out_got <= result.got;
            r_out_err <= result.err;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.got_index  = r_out_got;
    assign o_rsp.error_code = r_out_err;

endmodule

### tb/sv/tb_indexed_free_list_allocator.sv
module tb_indexed_free_list_allocator;
    import ifla_pkg::*;

    localparam int N_RANDOM        = 1930;
    localparam int FILL_PHASE      = 500;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 20;

    // opcodes the block does not decode
    localparam logic [OPC_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OPC_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [GOT_W-1:0] got;
        t_err             err;
    } t_answer;

    // Mirror of the link arrays and the row ends; one answer per request.
    class alloc_scoreboard;
        t_link   nxt [RECORD_COUNT];
        t_link   prv [RECORD_COUNT];
        t_link   row_head;
        t_link   row_tail;
        t_answer answer_q[$];
        int      errors;

        function new();
            errors = 0;
            rebuild_ring();
        endfunction

        function void rebuild_ring();
            for (int i = 0; i < RECORD_COUNT; i++) begin
                nxt[i] = t_link'((i + 1) % RECORD_COUNT);
                prv[i] = t_link'((i + RECORD_COUNT - 1) % RECORD_COUNT);
            end
            row_head = '0;
            row_tail = '0;
        endfunction

        function t_link pop_free();
            t_link w;
            t_link after;
            w = nxt[0];
            if (w == 0) return '0;
            after      = nxt[w];
            nxt[0]     = after;
            prv[after] = '0;
            nxt[w]     = '0;
            prv[w]     = '0;
            return w;
        endfunction

        function void link_after_tail(t_link r);
            if (row_tail == 0) begin
                row_head = r;
            end else begin
                nxt[row_tail] = r;
            end
            prv[r]   = row_tail;
            nxt[r]   = '0;
            row_tail = r;
        endfunction

        function void return_record(t_link r);
            t_link p;
            t_link n;
            t_link hd;
            p = prv[r];
            n = nxt[r];
            if (p != 0) nxt[p] = n;
            else if (row_head == r) row_head = n;
            if (n != 0) prv[n] = p;
            else if (row_tail == r) row_tail = p;
            // free head is read after the unlink
            hd      = nxt[0];
            nxt[r]  = hd;
            prv[r]  = '0;
            prv[hd] = r;
            nxt[0]  = r;
        endfunction

        function logic [GOT_W-1:0] note_request(logic [OPC_W-1:0] op,
                                                logic [IDX_W-1:0] idx);
            t_answer a;
            logic    idx_ok;
            a.got  = '0;
            a.err  = ERR_OK;
            idx_ok = (idx != 0) && (int'(idx) < RECORD_COUNT);
            case (op)
                OP_CLEAR: begin
                    rebuild_ring();
                end
                OP_START: begin
                    a.got = pop_free();
                    if (a.got == 0) begin
                        a.err = ERR_EMPTY;
                    end else begin
                        row_head = a.got;
                        row_tail = a.got;
                    end
                end
                OP_TAKE: begin
                    a.got = pop_free();
                    if (a.got == 0) a.err = ERR_EMPTY;
                end
                OP_APPEND: begin
                    if (idx_ok) link_after_tail(t_link'(idx));
                    else a.err = ERR_INDEX;
                end
                OP_GIVE: begin
                    if (idx_ok) return_record(t_link'(idx));
                    else a.err = ERR_INDEX;
                end
                default: ;
            endcase
            answer_q.push_back(a);
            return a.got;
        endfunction

        function void check_result(logic [GOT_W-1:0] got, logic [ERR_W-1:0] err);
            t_answer a;
            if (answer_q.size() == 0) begin
                $display("ERROR t=%0t response beat with nothing pending: %s %0d %s %0d",
                         $time, "got_index", got, "error_code", err);
                errors++;
                return;
            end
            a = answer_q.pop_front();
            if (got !== a.got) begin
                $display("ERROR t=%0t got_index expected %0d actual %0d", $time, a.got, got);
                errors++;
            end
            if (err !== a.err) begin
                $display("ERROR t=%0t error_code expected %0d actual %0d", $time, a.err, err);
                errors++;
            end
        endfunction

        function int pending();
            return answer_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ifla_req_if req_ch ();
    ifla_rsp_if rsp_ch ();

    indexed_free_list_allocator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    alloc_scoreboard sb = new();

    bit idle_en      = 1'b1;
    bit hold_off_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // One request beat; called at a falling edge, returns at a falling edge.
    task automatic send_req(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] idx,
                            output logic [GOT_W-1:0] got);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= op;
        req_ch.record_index <= idx;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        got = sb.note_request(op, idx);
        @(negedge i_clk);
    endtask

    // response side: random stalls plus one long hold-off
    initial begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                stall_left   = int'($urandom_range(1, 8)) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                sb.check_result(rsp_ch.got_index, rsp_ch.error_code);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR t=%0t watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        logic [GOT_W-1:0] got;
        logic [GOT_W-1:0] spare;
        logic [OPC_W-1:0] op;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] loose[$];  // taken, not in a row
        logic [IDX_W-1:0] held[$];   // in the current or an abandoned row
        int               roll;
        int               k;
        bit               fill;

        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = OP_CLEAR;
        req_ch.record_index = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // build a row of three, then unlink middle, head and last record
        send_req(OP_TAKE,   8'd0,   got);
        send_req(OP_TAKE,   8'd0,   got);
        send_req(OP_START,  8'd255, got);
        send_req(OP_APPEND, 8'd1,   got);
        send_req(OP_APPEND, 8'd2,   got);
        send_req(OP_GIVE,   8'd1,   got);
        send_req(OP_GIVE,   8'd3,   got);
        send_req(OP_GIVE,   8'd2,   got);
        // index zero on both indexed requests
        send_req(OP_APPEND, 8'd0,   got);
        send_req(OP_GIVE,   8'd0,   got);
        send_req(OP_SPARE_LO,        8'd255, got);
        send_req(OP_SPARE_LO + 3'd1, 8'd0,   got);
        send_req(OP_SPARE_HI,        8'd170, got);
        // append with no row, then a start row over an existing row
        send_req(OP_TAKE,   8'd85,  spare);
        send_req(OP_APPEND, spare,  got);
        send_req(OP_START,  8'd0,   got);
        send_req(OP_GIVE,   8'd255, got);
        // a record whose next link is 0 taken from the free head empties the pool
        send_req(OP_CLEAR,  8'd0,   got);
        send_req(OP_APPEND, 8'd1,   got);
        send_req(OP_TAKE,   8'd0,   got);
        send_req(OP_TAKE,   8'd0,   got);
        send_req(OP_START,  8'd0,   got);
        send_req(OP_GIVE,   8'd5,   got);
        send_req(OP_CLEAR,  8'd255, got);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) hold_off_req = 1'b1;
            if (i >= N_RANDOM * 85 / 100) idle_en = 1'b0;
            fill = ((i / FILL_PHASE) % 2) == 0;
            idx  = IDX_W'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 15) begin
                // noise: any request, any index, no clear
                op = OPC_W'($urandom_range(OP_SPARE_HI, OP_START));
            end else begin
                roll = $urandom_range(0, 99);
                if (fill)
                    op = roll < 65 ? OP_TAKE : roll < 75 ? OP_START :
                         roll < 85 ? OP_APPEND : OP_GIVE;
                else
                    op = roll < 3 ? OP_CLEAR : roll < 18 ? OP_TAKE : roll < 23 ? OP_START :
                         roll < 38 ? OP_APPEND : OP_GIVE;
                if (op == OP_APPEND) begin
                    if (loose.size() > 0) begin
                        k   = $urandom_range(0, loose.size() - 1);
                        idx = loose[k];
                        loose.delete(k);
                        held.push_back(idx);
                    end else begin
                        op = OP_TAKE;
                    end
                end else if (op == OP_GIVE) begin
                    if (loose.size() > 0 && (held.size() == 0 || $urandom_range(0, 1) == 0)) begin
                        k   = $urandom_range(0, loose.size() - 1);
                        idx = loose[k];
                        loose.delete(k);
                    end else if (held.size() > 0) begin
                        k   = $urandom_range(0, held.size() - 1);
                        idx = held[k];
                        held.delete(k);
                    end else begin
                        op = OP_TAKE;
                    end
                end
            end
            send_req(op, idx, got);
            case (op)
                OP_CLEAR: begin
                    loose.delete();
                    held.delete();
                end
                OP_TAKE:  if (got != 0) loose.push_back(got);
                OP_START: if (got != 0) held.push_back(got);
                default: ;
            endcase
        end
        req_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
